// ----- sv/nplf_pkg.sv -----
// Package: shared types, constants and fixed-point helpers for the panel lift/drag block.
`default_nettype none
package nplf_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_COS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DENSITY  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRESSURE = 3'd4;

  localparam logic [17:0] COS_RESET = 18'h10000;

  localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

  // One panel after the front end
  typedef struct packed {
    logic signed [36:0] d;
    logic               windward;
    logic signed [17:0] nx;
    logic signed [17:0] ny;
    logic signed [17:0] nz;
    logic [31:0]        area;
    logic               last;
  } item_t;

  typedef struct packed {
    logic               start;
    logic signed [63:0] a;
    logic signed [63:0] b;
  } mul_req_t;

  typedef struct packed {
    logic                done;
    logic signed [127:0] p;
  } mul_rsp_t;

  typedef struct packed {
    logic               ovf;
    logic signed [63:0] val;
  } sat_t;

  typedef enum logic [1:0] {BE_IDLE, BE_ISSUE, BE_WAIT, BE_EMIT} be_state_t;

  typedef enum logic [3:0] {
    OP_CP, OP_V2, OP_Q, OP_P, OP_PA, OP_TX, OP_TY, OP_TZ,
    OP_L1, OP_L2, OP_D1, OP_D2
  } op_t;

  function automatic op_t next_op(input op_t op);
    op_t r;
    unique case (op)
      OP_CP:   r = OP_V2;
      OP_V2:   r = OP_Q;
      OP_Q:    r = OP_P;
      OP_P:    r = OP_PA;
      OP_PA:   r = OP_TX;
      OP_TX:   r = OP_TY;
      OP_TY:   r = OP_TZ;
      OP_TZ:   r = OP_L1;
      OP_L1:   r = OP_L2;
      OP_L2:   r = OP_D1;
      OP_D1:   r = OP_D2;
      OP_D2:   r = OP_CP;
      default: r = OP_CP;
    endcase
    return r;
  endfunction

  // Clamp to signed 64 bits
  function automatic sat_t sat64(input logic signed [127:0] v);
    sat_t r;
    if (v[127:63] != {65{v[63]}}) begin
      r.ovf = 1'b1;
      r.val = v[127] ? S64_MIN : S64_MAX;
    end else begin
      r.ovf = 1'b0;
      r.val = v[63:0];
    end
    return r;
  endfunction

  // Round half up, then arithmetic shift right; sh is a constant at each call
  function automatic logic signed [127:0] rnd128(input logic signed [127:0] v,
                                                 input int unsigned sh);
    logic signed [127:0] t;
    t = v + (128'sd1 <<< (sh - 1));
    return t >>> sh;
  endfunction

  function automatic sat_t sat_add64(input logic signed [63:0] a,
                                     input logic signed [63:0] b);
    logic signed [127:0] s;
    s = $signed({{64{a[63]}}, a}) + $signed({{64{b[63]}}, b});
    return sat64(s);
  endfunction

endpackage
`default_nettype wire

// ----- sv/newtonian_panel_lift_drag.sv -----
// Top level: config registers, front end, panel queue, back end and shared multiplier.
// Sequence: the back end runs eight multiplies per panel (seven when leeward) through the
//   shared 64x16-per-cycle multiplier, one multiply at a time.
// A last panel adds four rotation multiplies before the result is posted.
// The back end takes one panel at a time; the queue takes new panels meanwhile.
// Reset (synchronous, rst_n low): cos = 1.0, other registers, sums and flag cleared.
`default_nettype none
module newtonian_panel_lift_drag #(
  parameter int unsigned QUEUE_DEPTH = nplf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  cfg_we,
  input  wire [nplf_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [nplf_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  wire                                  in_push,
  output logic                                 in_full,
  input  wire signed [17:0]                    in_normal_x,
  input  wire signed [17:0]                    in_normal_y,
  input  wire signed [17:0]                    in_normal_z,
  input  wire        [31:0]                    in_panel_area,
  input  wire                                  in_last_panel,
  output logic                                 out_empty,
  input  wire                                  out_pop,
  output logic signed [63:0]                   out_lift,
  output logic signed [63:0]                   out_drag,
  output logic                                 out_saturated
);
  import nplf_pkg::*;

  logic signed [17:0] cos_r, cos_nxt, sin_r, sin_nxt;
  logic [31:0] speed_r, speed_nxt, dens_r, dens_nxt, pres_r, pres_nxt;

  item_t    f_item, b_item;
  logic     q_wr, q_rd, q_full, q_empty;
  mul_req_t mreq;
  mul_rsp_t mrsp;

  // Configuration writes
  always_comb begin
    cos_nxt = cos_r; sin_nxt = sin_r; speed_nxt = speed_r; dens_nxt = dens_r;
    pres_nxt = pres_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_COS:      cos_nxt   = cfg_data[17:0];
        CFG_SIN:      sin_nxt   = cfg_data[17:0];
        CFG_SPEED:    speed_nxt = cfg_data;
        CFG_DENSITY:  dens_nxt  = cfg_data;
        CFG_PRESSURE: pres_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_r   <= COS_RESET;
      sin_r   <= '0;
      speed_r <= '0;
      dens_r  <= '0;
      pres_r  <= '0;
    end else begin
      cos_r   <= cos_nxt;
      sin_r   <= sin_nxt;
      speed_r <= speed_nxt;
      dens_r  <= dens_nxt;
      pres_r  <= pres_nxt;
    end
  end

  assign in_full = q_full;

  nplf_front u_front (
    .push       (in_push),
    .q_full     (q_full),
    .normal_x   (in_normal_x),
    .normal_y   (in_normal_y),
    .normal_z   (in_normal_z),
    .panel_area (in_panel_area),
    .last_panel (in_last_panel),
    .cos_angle  (cos_r),
    .sin_angle  (sin_r),
    .q_wr       (q_wr),
    .q_item     (f_item)
  );

  nplf_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wr_item (f_item),
    .full    (q_full),
    .rd      (q_rd),
    .rd_item (b_item),
    .empty   (q_empty)
  );

  nplf_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  nplf_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .q_empty              (q_empty),
    .q_item               (b_item),
    .q_pop                (q_rd),
    .cos_angle            (cos_r),
    .sin_angle            (sin_r),
    .flow_speed           (speed_r),
    .air_density          (dens_r),
    .free_stream_pressure (pres_r),
    .mul_req              (mreq),
    .mul_rsp              (mrsp),
    .out_empty            (out_empty),
    .out_pop              (out_pop),
    .out_lift             (out_lift),
    .out_drag             (out_drag),
    .out_saturated        (out_saturated)
  );

endmodule
`default_nettype wire

// ----- sv/nplf_mul.sv -----
// Shared multiplier: signed 64 x 64 -> 128, one 16-bit digit of b per cycle.
`default_nettype none
module nplf_mul (
  input  wire                  clk,
  input  wire                  rst_n,
  input  nplf_pkg::mul_req_t   req,
  output nplf_pkg::mul_rsp_t   rsp
);
  import nplf_pkg::*;

  logic         busy_r, busy_nxt;
  logic         fin_r, fin_nxt;
  logic         done_r, done_nxt;
  logic [1:0]   cnt_r, cnt_nxt;
  logic [63:0]  mag_a_r, mag_a_nxt;
  logic [63:0]  mag_b_r, mag_b_nxt;
  logic         neg_r, neg_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic signed [127:0] p_r, p_nxt;
  logic [79:0]  part;

  assign part = mag_a_r * mag_b_r[63:48];

  // Horner accumulation, most significant digit first
  always_comb begin
    busy_nxt  = busy_r;
    fin_nxt   = 1'b0;
    done_nxt  = fin_r;
    cnt_nxt   = cnt_r;
    mag_a_nxt = mag_a_r;
    mag_b_nxt = mag_b_r;
    neg_nxt   = neg_r;
    acc_nxt   = acc_r;
    p_nxt     = p_r;
    if (req.start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = 2'd0;
      mag_a_nxt = req.a[63] ? 64'(-req.a) : 64'(req.a);
      mag_b_nxt = req.b[63] ? 64'(-req.b) : 64'(req.b);
      neg_nxt   = req.a[63] ^ req.b[63];
      acc_nxt   = '0;
    end else if (busy_r) begin
      acc_nxt   = (acc_r << 16) + {48'b0, part};
      mag_b_nxt = mag_b_r << 16;
      cnt_nxt   = cnt_r + 2'd1;
      if (cnt_r == 2'd3) begin
        busy_nxt = 1'b0;
        fin_nxt  = 1'b1;
      end
    end
    if (fin_r) begin
      p_nxt = neg_r ? -$signed(acc_r) : $signed(acc_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      busy_r <= busy_nxt;
      fin_r  <= fin_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    mag_a_r <= mag_a_nxt;
    mag_b_r <= mag_b_nxt;
    neg_r   <= neg_nxt;
    acc_r   <= acc_nxt;
    p_r     <= p_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.p    = p_r;

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> (!busy_r && !fin_r))
    else $error("multiply started while busy");

endmodule
`default_nettype wire

// ----- sv/nplf_queue.sv -----
// Short item queue between the front and back ends.
`default_nettype none
module nplf_queue #(
  parameter int unsigned DEPTH = nplf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 wr,
  input  nplf_pkg::item_t     wr_item,
  output logic                full,
  input  wire                 rd,
  output nplf_pkg::item_t     rd_item,
  output logic                empty
);
  import nplf_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign full    = (cnt_r == CNT_FULL);
  assign empty   = (cnt_r == '0);
  assign rd_item = mem_r[rp_r];

  // Pointer and count update
  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (wr) wp_nxt = (wp_r == PTR_LAST) ? '0 : wp_r + PTR_W'(1);
    if (rd) rp_nxt = (rp_r == PTR_LAST) ? '0 : rp_r + PTR_W'(1);
    if (wr && !rd)      cnt_nxt = cnt_r + CNT_W'(1);
    else if (rd && !wr) cnt_nxt = cnt_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
    if (wr) mem_r[wp_r] <= wr_item;
  end

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    !(full && wr) && !(empty && rd))
    else $error("queue overrun or underrun");

endmodule
`default_nettype wire

// ----- sv/nplf_front.sv -----
// Front end: takes panels, forms the flow dot product and marks windward panels.
`default_nettype none
module nplf_front (
  input  wire               push,
  input  wire               q_full,
  input  wire signed [17:0] normal_x,
  input  wire signed [17:0] normal_y,
  input  wire signed [17:0] normal_z,
  input  wire        [31:0] panel_area,
  input  wire               last_panel,
  input  wire signed [17:0] cos_angle,
  input  wire signed [17:0] sin_angle,
  output logic              q_wr,
  output nplf_pkg::item_t   q_item
);
  import nplf_pkg::*;

  logic signed [35:0] pc, ps;
  logic signed [36:0] d;

  // d = cos*nx + sin*ny, exact
  assign pc = cos_angle * normal_x;
  assign ps = sin_angle * normal_y;
  assign d  = $signed({pc[35], pc}) + $signed({ps[35], ps});

  always_comb begin
    q_item.d        = d;
    q_item.windward = d[36];
    q_item.nx       = normal_x;
    q_item.ny       = normal_y;
    q_item.nz       = normal_z;
    q_item.area     = panel_area;
    q_item.last     = last_panel;
  end

  assign q_wr = push && !q_full;

endmodule
`default_nettype wire

// ----- sv/nplf_back.sv -----
// Back end: sequences the per-panel multiplies, accumulates forces, emits lift/drag.
`default_nettype none
module nplf_back (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 q_empty,
  input  nplf_pkg::item_t     q_item,
  output logic                q_pop,
  input  wire signed [17:0]   cos_angle,
  input  wire signed [17:0]   sin_angle,
  input  wire        [31:0]   flow_speed,
  input  wire        [31:0]   air_density,
  input  wire        [31:0]   free_stream_pressure,
  output nplf_pkg::mul_req_t  mul_req,
  input  nplf_pkg::mul_rsp_t  mul_rsp,
  output logic                out_empty,
  input  wire                 out_pop,
  output logic signed [63:0]  out_lift,
  output logic signed [63:0]  out_drag,
  output logic                out_saturated
);
  import nplf_pkg::*;

  be_state_t state_r, state_nxt;
  op_t       op_r, op_nxt;
  item_t     item_r;

  logic signed [63:0] cp_r, cp_nxt, v2_r, v2_nxt, q_r, q_nxt, p_r, p_nxt, pa_r, pa_nxt;
  logic signed [63:0] sx_r, sx_nxt, sy_r, sy_nxt, sz_r, sz_nxt;
  logic signed [127:0] tmp_r, tmp_nxt;
  logic signed [63:0] lift_r, lift_nxt, drag_r, drag_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ov_r, ov_nxt;
  logic signed [63:0] ol_r, ol_nxt, od_r, od_nxt;
  logic               os_r, os_nxt;

  logic post_en, emit, emit_go;
  logic signed [63:0] ca, sa;
  sat_t r16, r17, r47, rp0, padd, sadd, lsat, dsat;
  logic signed [63:0] sum_sel;

  assign ca = 64'(cos_angle);
  assign sa = 64'(sin_angle);
  assign emit_go = !ov_r || out_pop;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BE_IDLE:  if (!q_empty) state_nxt = BE_ISSUE;
      BE_ISSUE: state_nxt = BE_WAIT;
      BE_WAIT:
        if (mul_rsp.done) begin
          if (op_r == OP_TZ && !item_r.last) state_nxt = BE_IDLE;
          else if (op_r == OP_D2)            state_nxt = BE_EMIT;
          else                               state_nxt = BE_ISSUE;
        end
      BE_EMIT:  if (emit_go) state_nxt = BE_IDLE;
      default:  state_nxt = BE_IDLE;
    endcase
  end

  // State outputs and multiplier operand select
  always_comb begin
    q_pop         = (state_r == BE_IDLE) && !q_empty;
    post_en       = (state_r == BE_WAIT) && mul_rsp.done;
    emit          = (state_r == BE_EMIT) && emit_go;
    mul_req.start = (state_r == BE_ISSUE);
    mul_req.a     = '0;
    mul_req.b     = '0;
    unique case (op_r)
      OP_CP: begin mul_req.a = 64'(item_r.d);     mul_req.b = 64'(item_r.d);     end
      OP_V2: begin mul_req.a = 64'(flow_speed);   mul_req.b = 64'(flow_speed);   end
      OP_Q:  begin mul_req.a = 64'(air_density);  mul_req.b = v2_r;              end
      OP_P:  begin mul_req.a = cp_r;              mul_req.b = q_r;               end
      OP_PA: begin mul_req.a = p_r;               mul_req.b = 64'(item_r.area);  end
      OP_TX: begin mul_req.a = pa_r;              mul_req.b = -64'(item_r.nx);   end
      OP_TY: begin mul_req.a = pa_r;              mul_req.b = -64'(item_r.ny);   end
      OP_TZ: begin mul_req.a = pa_r;              mul_req.b = -64'(item_r.nz);   end
      OP_L1: begin mul_req.a = sy_r;              mul_req.b = ca;                end
      OP_L2: begin mul_req.a = sx_r;              mul_req.b = sa;                end
      OP_D1: begin mul_req.a = sy_r;              mul_req.b = sa;                end
      OP_D2: begin mul_req.a = sx_r;              mul_req.b = ca;                end
      default: ;
    endcase
  end

  // Rounding and saturation of the finished product
  always_comb begin
    r16  = sat64(rnd128(mul_rsp.p, 16));
    r17  = sat64(rnd128(mul_rsp.p, 17));
    r47  = sat64(rnd128(mul_rsp.p, 47));
    rp0  = sat64(mul_rsp.p);
    padd = sat_add64(r16.val, 64'(free_stream_pressure));
    unique case (op_r)
      OP_TX:   sum_sel = sx_r;
      OP_TY:   sum_sel = sy_r;
      default: sum_sel = sz_r;
    endcase
    sadd = sat_add64(sum_sel, r16.val);
    lsat = sat64(rnd128(tmp_r - mul_rsp.p, 16));
    dsat = sat64(rnd128(tmp_r + mul_rsp.p, 16));
  end

  // Datapath update
  always_comb begin
    op_nxt = op_r; cp_nxt = cp_r; v2_nxt = v2_r; q_nxt = q_r; p_nxt = p_r;
    pa_nxt = pa_r; sx_nxt = sx_r; sy_nxt = sy_r; sz_nxt = sz_r; tmp_nxt = tmp_r;
    lift_nxt = lift_r; drag_nxt = drag_r; ovf_nxt = ovf_r;
    ov_nxt = ov_r; ol_nxt = ol_r; od_nxt = od_r; os_nxt = os_r;
    if (q_pop) begin
      op_nxt = q_item.windward ? OP_CP : OP_V2;
      cp_nxt = '0;
    end
    if (post_en) begin
      op_nxt = next_op(op_r);
      unique case (op_r)
        OP_CP: begin cp_nxt = r47.val; ovf_nxt = ovf_r | r47.ovf; end
        OP_V2: begin v2_nxt = r16.val; ovf_nxt = ovf_r | r16.ovf; end
        OP_Q:  begin q_nxt  = r17.val; ovf_nxt = ovf_r | r17.ovf; end
        OP_P:  begin p_nxt  = padd.val; ovf_nxt = ovf_r | r16.ovf | padd.ovf; end
        OP_PA: begin pa_nxt = rp0.val; ovf_nxt = ovf_r | rp0.ovf; end
        OP_TX: begin sx_nxt = sadd.val; ovf_nxt = ovf_r | r16.ovf | sadd.ovf; end
        OP_TY: begin sy_nxt = sadd.val; ovf_nxt = ovf_r | r16.ovf | sadd.ovf; end
        OP_TZ: begin sz_nxt = sadd.val; ovf_nxt = ovf_r | r16.ovf | sadd.ovf; end
        OP_L1: tmp_nxt = mul_rsp.p;
        OP_L2: begin lift_nxt = lsat.val; ovf_nxt = ovf_r | lsat.ovf; end
        OP_D1: tmp_nxt = mul_rsp.p;
        OP_D2: begin drag_nxt = dsat.val; ovf_nxt = ovf_r | dsat.ovf; end
        default: ;
      endcase
    end
    // Result slot
    if (out_pop && ov_r) ov_nxt = 1'b0;
    if (emit) begin
      ov_nxt  = 1'b1;
      ol_nxt  = lift_r;
      od_nxt  = drag_r;
      os_nxt  = ovf_r;
      sx_nxt  = '0;
      sy_nxt  = '0;
      sz_nxt  = '0;
      ovf_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BE_IDLE;
      op_r    <= OP_CP;
      sx_r    <= '0;
      sy_r    <= '0;
      sz_r    <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sx_r    <= sx_nxt;
      sy_r    <= sy_nxt;
      sz_r    <= sz_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
    if (q_pop) item_r <= q_item;
    cp_r   <= cp_nxt;
    v2_r   <= v2_nxt;
    q_r    <= q_nxt;
    p_r    <= p_nxt;
    pa_r   <= pa_nxt;
    tmp_r  <= tmp_nxt;
    lift_r <= lift_nxt;
    drag_r <= drag_nxt;
    ol_r   <= ol_nxt;
    od_r   <= od_nxt;
    os_r   <= os_nxt;
  end

  assign out_empty     = !ov_r;
  assign out_lift      = ol_r;
  assign out_drag      = od_r;
  assign out_saturated = os_r;

  a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> (sx_r == '0 && sy_r == '0 && sz_r == '0 && !ovf_r))
    else $error("sums not cleared after result");

  a_emit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == BE_EMIT) |-> item_r.last)
    else $error("result for a panel not marked last");

endmodule
`default_nettype wire
